// ===== rtl/cdiv_pkg.sv =====
package cdiv_pkg;

  // Field format of the stream.
  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 8;

  // Derived widths: signed products, signed sums, magnitudes and the scaled numerator.
  localparam int PROD_W  = 2 * DATA_WIDTH;
  localparam int SUM_W   = 2 * DATA_WIDTH + 1;
  localparam int MAG_W   = 2 * DATA_WIDTH;
  localparam int SCALE_W = MAG_W + FRAC_BITS;

  typedef logic signed [DATA_WIDTH-1:0] data_t;

  // One accepted input request.
  typedef struct packed {
    data_t dividend_re;
    data_t dividend_im;
    data_t divisor_re;
    data_t divisor_im;
    logic  last;
  } in_item_t;

  // One quotient part while it passes through the divider stages.
  typedef struct packed {
    logic                  ovf;
    logic                  neg;
    logic [MAG_W-1:0]      rem;
    logic [DATA_WIDTH-1:0] lo;
    logic [DATA_WIDTH-1:0] q;
  } lane_t;

  // Divider pipeline word; the valid bit travels with the data.
  typedef struct packed {
    logic             valid;
    logic             zero;
    logic             last;
    logic [MAG_W-1:0] msq;
    lane_t            re;
    lane_t            im;
  } div_item_t;

  // One finished result request.
  typedef struct packed {
    data_t quotient_re;
    data_t quotient_im;
    logic  zero_divisor;
    logic  saturated;
    logic  last_out;
  } result_t;

  // Status of the output buffer as seen by the top level.
  typedef struct packed {
    logic out_valid;
    logic skid_valid;
    logic pipe_en;
  } out_stat_t;

endpackage

// ===== rtl/cdiv_in_if.sv =====
interface cdiv_in_if;
  import cdiv_pkg::*;

  logic  valid;
  logic  ready;
  data_t dividend_re;
  data_t dividend_im;
  data_t divisor_re;
  data_t divisor_im;
  logic  last_in;

  modport source (
    output valid, dividend_re, dividend_im, divisor_re, divisor_im, last_in,
    input  ready
  );

  modport sink (
    input  valid, dividend_re, dividend_im, divisor_re, divisor_im, last_in,
    output ready
  );

endinterface

// ===== rtl/cdiv_out_if.sv =====
interface cdiv_out_if;
  import cdiv_pkg::*;

  logic  valid;
  logic  ready;
  data_t quotient_re;
  data_t quotient_im;
  logic  zero_divisor;
  logic  saturated;
  logic  last_out;

  modport source (
    output valid, quotient_re, quotient_im, zero_divisor, saturated, last_out,
    input  ready
  );

  modport sink (
    input  valid, quotient_re, quotient_im, zero_divisor, saturated, last_out,
    output ready
  );

endinterface

// ===== rtl/complex_divide_stream_unit.sv =====
// Channel   Port     Direction  Contents
// input     in_ch    sink       dividend and divisor (re, im), last_in
// result    out_ch   source     quotient (re, im), zero_divisor, saturated, last_out
//
// One request is taken per cycle while the skid entry is empty. The pipeline holds
// the front stages of products, sums, magnitudes and set-up, the restoring divider
// stages (one quotient bit per stage for both parts), and the output register.
// Reset (rst_n low at a clock edge) clears every valid bit and the skid entry.
// When the result is not taken, the skid entry catches the request in flight
// and all stages then hold together until the skid entry drains.
module complex_divide_stream_unit (
  input logic      clk,
  input logic      rst_n,
  cdiv_in_if.sink  in_ch,
  cdiv_out_if.source out_ch
);
  import cdiv_pkg::*;

  in_item_t  in_item;
  div_item_t stg [0:DATA_WIDTH];
  result_t   res;
  out_stat_t stat;

  // Input request packing.
  assign in_item.dividend_re = in_ch.dividend_re;
  assign in_item.dividend_im = in_ch.dividend_im;
  assign in_item.divisor_re  = in_ch.divisor_re;
  assign in_item.divisor_im  = in_ch.divisor_im;
  assign in_item.last        = in_ch.last_in;
  assign in_ch.ready         = stat.pipe_en;

  cdiv_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (stat.pipe_en),
    .in_valid (in_ch.valid),
    .in_item  (in_item),
    .d_out    (stg[0])
  );

  // Divider stages, one quotient bit each.
  for (genvar g = 0; g < DATA_WIDTH; g++) begin : g_div
    cdiv_div_stage u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (stat.pipe_en),
      .d_in  (stg[g]),
      .d_out (stg[g+1])
    );
  end

  cdiv_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .d_in      (stg[DATA_WIDTH]),
    .out_ready (out_ch.ready),
    .res       (res),
    .stat      (stat)
  );

  // Result request unpacking.
  assign out_ch.valid        = stat.out_valid;
  assign out_ch.quotient_re  = res.quotient_re;
  assign out_ch.quotient_im  = res.quotient_im;
  assign out_ch.zero_divisor = res.zero_divisor;
  assign out_ch.saturated    = res.saturated;
  assign out_ch.last_out     = res.last_out;

  // A zero divisor always gives cleared, unsaturated quotients.
  a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.zero_divisor |->
      out_ch.quotient_re == '0 && out_ch.quotient_im == '0 && !out_ch.saturated)
    else $error("zero divisor result not cleared");

  // The skid entry is only ever occupied behind a held output request.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    stat.skid_valid |-> stat.out_valid)
    else $error("skid entry holds data with output empty");

  // A request leaving the pipeline into a blocked output lands in the skid entry.
  a_skid_catch: assert property (@(posedge clk) disable iff (!rst_n)
    stat.out_valid && !out_ch.ready && stat.pipe_en && stg[DATA_WIDTH].valid
      |=> stat.skid_valid)
    else $error("request from the pipeline lost at the output");

endmodule

// ===== rtl/cdiv_front.sv =====
module cdiv_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  cdiv_pkg::in_item_t   in_item,
  output cdiv_pkg::div_item_t  d_out
);
  import cdiv_pkg::*;

  // Stage 1: the six signed products.
  logic                    v1_r;
  logic                    last1_r;
  logic signed [PROD_W-1:0] rr_r, ii_r, ar_br_r, ai_bi_r, ai_br_r, ar_bi_r;

  // Stage 2: squared magnitude and the two numerators.
  logic                    v2_r;
  logic                    last2_r;
  logic [MAG_W-1:0]        msq2_r;
  logic signed [SUM_W-1:0] nre_r, nim_r;

  // Stage 3: sign and magnitude of each numerator.
  logic                    v3_r;
  logic                    last3_r;
  logic                    zero3_r;
  logic [MAG_W-1:0]        msq3_r;
  logic                    neg_re_r, neg_im_r;
  logic [MAG_W-1:0]        mag_re_r, mag_im_r;

  // Stage 4: divider set-up with the overflow check.
  logic                    v4_r;
  div_item_t               item_r, item_nxt;

  // The scaled numerator's upper part starts the remainder; if it already
  // reaches the divisor the quotient cannot fit in the output field.
  function automatic lane_t lane_setup(logic neg, logic [MAG_W-1:0] mag,
                                       logic [MAG_W-1:0] d);
    logic [SCALE_W-1:0] sc;
    logic [MAG_W-1:0]   head;
    lane_t              r;
    sc    = SCALE_W'(mag) << FRAC_BITS;
    head  = MAG_W'(sc >> DATA_WIDTH);
    r.ovf = (head >= d);
    r.neg = neg;
    r.rem = head;
    r.lo  = sc[DATA_WIDTH-1:0];
    r.q   = '0;
    return r;
  endfunction

  // Valid bits of the four stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // Products of the operand pairs.
  always_ff @(posedge clk) begin
    if (en) begin
      last1_r <= in_item.last;
      rr_r    <= in_item.divisor_re * in_item.divisor_re;
      ii_r    <= in_item.divisor_im * in_item.divisor_im;
      ar_br_r <= in_item.dividend_re * in_item.divisor_re;
      ai_bi_r <= in_item.dividend_im * in_item.divisor_im;
      ai_br_r <= in_item.dividend_im * in_item.divisor_re;
      ar_bi_r <= in_item.dividend_re * in_item.divisor_im;
    end
  end

  // Sums; both squares are non-negative, so their sum is taken unsigned.
  always_ff @(posedge clk) begin
    if (en) begin
      last2_r <= last1_r;
      msq2_r  <= MAG_W'(rr_r) + MAG_W'(ii_r);
      nre_r   <= SUM_W'(ar_br_r) + SUM_W'(ai_bi_r);
      nim_r   <= SUM_W'(ai_br_r) - SUM_W'(ar_bi_r);
    end
  end

  // Absolute values of the numerators.
  always_ff @(posedge clk) begin
    if (en) begin
      last3_r  <= last2_r;
      zero3_r  <= (msq2_r == '0);
      msq3_r   <= msq2_r;
      neg_re_r <= nre_r[SUM_W-1];
      neg_im_r <= nim_r[SUM_W-1];
      mag_re_r <= MAG_W'(nre_r[SUM_W-1] ? -nre_r : nre_r);
      mag_im_r <= MAG_W'(nim_r[SUM_W-1] ? -nim_r : nim_r);
    end
  end

  // Divider set-up.
  always_comb begin
    item_nxt       = '0;
    item_nxt.valid = v3_r;
    item_nxt.zero  = zero3_r;
    item_nxt.last  = last3_r;
    item_nxt.msq   = msq3_r;
    item_nxt.re    = lane_setup(neg_re_r, mag_re_r, msq3_r);
    item_nxt.im    = lane_setup(neg_im_r, mag_im_r, msq3_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= item_nxt;
    end
  end

  always_comb begin
    d_out       = item_r;
    d_out.valid = v4_r;
  end

endmodule

// ===== rtl/cdiv_div_stage.sv =====
module cdiv_div_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  cdiv_pkg::div_item_t d_in,
  output cdiv_pkg::div_item_t d_out
);
  import cdiv_pkg::*;

  logic      valid_r;
  div_item_t item_r, item_nxt;

  // One restoring step: shift in the next dividend bit and subtract if it fits.
  function automatic lane_t div_step(lane_t a, logic [MAG_W-1:0] d);
    logic [MAG_W:0] t;
    lane_t          r;
    r    = a;
    t    = {a.rem, a.lo[DATA_WIDTH-1]};
    r.lo = {a.lo[DATA_WIDTH-2:0], 1'b0};
    if (t >= {1'b0, d}) begin
      r.rem = MAG_W'(t - {1'b0, d});
      r.q   = {a.q[DATA_WIDTH-2:0], 1'b1};
    end else begin
      r.rem = t[MAG_W-1:0];
      r.q   = {a.q[DATA_WIDTH-2:0], 1'b0};
    end
    return r;
  endfunction

  always_comb begin
    item_nxt    = d_in;
    item_nxt.re = div_step(d_in.re, d_in.msq);
    item_nxt.im = div_step(d_in.im, d_in.msq);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= d_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= item_nxt;
    end
  end

  always_comb begin
    d_out       = item_r;
    d_out.valid = valid_r;
  end

endmodule

// ===== rtl/cdiv_out.sv =====
module cdiv_out (
  input  logic                clk,
  input  logic                rst_n,
  input  cdiv_pkg::div_item_t d_in,
  input  logic                out_ready,
  output cdiv_pkg::result_t   res,
  output cdiv_pkg::out_stat_t stat
);
  import cdiv_pkg::*;

  logic    o_valid_r, o_valid_nxt;
  logic    s_valid_r, s_valid_nxt;
  result_t o_data_r, o_data_nxt;
  result_t s_data_r, s_data_nxt;
  result_t fin;
  logic    sat_re, sat_im;
  data_t   val_re, val_im;
  logic    arrive, o_free;

  // Clip the quotient magnitude to the signed range and apply the sign.
  function automatic data_t lane_finish(lane_t l, output logic sat);
    logic [DATA_WIDTH-1:0] lim;
    logic [DATA_WIDTH-1:0] mag;
    lim = {1'b0, {(DATA_WIDTH-1){1'b1}}} + DATA_WIDTH'(l.neg);
    sat = l.ovf || (l.q > lim);
    mag = sat ? lim : l.q;
    return l.neg ? data_t'(-mag) : data_t'(mag);
  endfunction

  // Result formation from the last divider stage.
  always_comb begin
    val_re = lane_finish(d_in.re, sat_re);
    val_im = lane_finish(d_in.im, sat_im);
    fin.last_out = d_in.last;
    if (d_in.zero) begin
      fin.quotient_re  = '0;
      fin.quotient_im  = '0;
      fin.zero_divisor = 1'b1;
      fin.saturated    = 1'b0;
    end else begin
      fin.quotient_re  = val_re;
      fin.quotient_im  = val_im;
      fin.zero_divisor = 1'b0;
      fin.saturated    = sat_re || sat_im;
    end
  end

  // Output register with a skid entry; the pipeline moves only while the
  // skid entry is empty, so the stall reaching the stages is registered.
  assign arrive = !s_valid_r && d_in.valid;
  assign o_free = !o_valid_r || out_ready;

  always_comb begin
    o_valid_nxt = o_valid_r;
    s_valid_nxt = s_valid_r;
    o_data_nxt  = o_data_r;
    s_data_nxt  = s_data_r;
    if (s_valid_r) begin
      if (out_ready) begin
        o_valid_nxt = 1'b1;
        o_data_nxt  = s_data_r;
        s_valid_nxt = 1'b0;
      end
    end else if (arrive) begin
      if (o_free) begin
        o_valid_nxt = 1'b1;
        o_data_nxt  = fin;
      end else begin
        s_valid_nxt = 1'b1;
        s_data_nxt  = fin;
      end
    end else if (out_ready) begin
      o_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
      s_valid_r <= 1'b0;
    end else begin
      o_valid_r <= o_valid_nxt;
      s_valid_r <= s_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    o_data_r <= o_data_nxt;
    s_data_r <= s_data_nxt;
  end

  assign res             = o_data_r;
  assign stat.out_valid  = o_valid_r;
  assign stat.skid_valid = s_valid_r;
  assign stat.pipe_en    = !s_valid_r;

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
  import cdiv_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_REPORTS = 10;

  logic clk;
  logic rst_n;

  cdiv_in_if  in_ch ();
  cdiv_out_if out_ch ();

  complex_divide_stream_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  result_t pending_quotients[$];
  int      mismatch_cnt;
  int      cycle_cnt;
  bit      gaps_on;
  bit      hold_req;
  int      hold_left;
  int      stall_left;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Scales one numerator by the fraction width, divides by the squared magnitude
  // with truncation toward zero and clips it to the output range.
  function automatic data_t scale_and_clip(longint num, longint msq, inout bit clipped);
    longint mag;
    longint q;
    longint lim;
    mag = (num < 0) ? -num : num;
    q   = (mag << FRAC_BITS) / msq;
    lim = longint'(1) << (DATA_WIDTH - 1);
    if (num >= 0) begin
      lim = lim - 1;
    end
    if (q > lim) begin
      q       = lim;
      clipped = 1'b1;
    end
    return data_t'((num < 0) ? -q : q);
  endfunction

  // Expected quotient of one input request.
  function automatic result_t divide_complex(in_item_t req);
    longint  ar;
    longint  ai;
    longint  br;
    longint  bi;
    longint  msq;
    longint  num_re;
    longint  num_im;
    bit      clipped;
    result_t res;
    ar  = longint'(req.dividend_re);
    ai  = longint'(req.dividend_im);
    br  = longint'(req.divisor_re);
    bi  = longint'(req.divisor_im);
    msq = br * br + bi * bi;
    clipped = 1'b0;
    res.last_out = req.last;
    if (msq == 0) begin
      res.quotient_re  = '0;
      res.quotient_im  = '0;
      res.zero_divisor = 1'b1;
      res.saturated    = 1'b0;
    end else begin
      num_re = ar * br + ai * bi;
      num_im = ai * br - ar * bi;
      res.quotient_re  = scale_and_clip(num_re, msq, clipped);
      res.quotient_im  = scale_and_clip(num_im, msq, clipped);
      res.zero_divisor = 1'b0;
      res.saturated    = clipped;
    end
    return res;
  endfunction

  function automatic in_item_t make_req(int a_re, int a_im, int b_re, int b_im, bit last);
    in_item_t req;
    req.dividend_re = data_t'(a_re);
    req.dividend_im = data_t'(a_im);
    req.divisor_re  = data_t'(b_re);
    req.divisor_im  = data_t'(b_im);
    req.last        = last;
    return req;
  endfunction

  // A value whose magnitude is spread over all scales, with a random sign.
  function automatic int spread_value();
    int v;
    v = int'($urandom_range(0, 32767) >> $urandom_range(0, 15));
    return $urandom_range(0, 1) ? -v - int'($urandom_range(0, 1)) : v;
  endfunction

  function automatic int corner_value();
    case ($urandom_range(0, 4))
      0: return -32768;
      1: return -1;
      2: return 0;
      3: return 1;
      default: return 32767;
    endcase
  endfunction

  // Random request; the mix favours saturation, zero divisors and corner values
  // as well as plain full-range operands.
  function automatic in_item_t random_req();
    in_item_t req;
    bit       last;
    last = ($urandom_range(0, 7) == 0);
    case ($urandom_range(0, 9))
      0: req = make_req(int'($urandom), int'($urandom), 0, 0, last);
      1, 2: req = make_req(int'($urandom), int'($urandom),
                           $urandom_range(0, 8) - 4, $urandom_range(0, 8) - 4, last);
      3, 4, 5: req = make_req(int'($urandom), int'($urandom), int'($urandom),
                              int'($urandom), last);
      6, 7, 8: req = make_req(spread_value(), spread_value(), spread_value(),
                              spread_value(), last);
      default: req = make_req(corner_value(), corner_value(), corner_value(),
                              corner_value(), last);
    endcase
    return req;
  endfunction

  // Offers one request and returns at the edge where it is accepted.
  task automatic send_req(in_item_t req);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.dividend_re <= req.dividend_re;
    in_ch.dividend_im <= req.dividend_im;
    in_ch.divisor_re  <= req.divisor_re;
    in_ch.divisor_im  <= req.divisor_im;
    in_ch.last_in     <= req.last;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
  endtask

  // Withdraws the last request and waits until every result has been checked.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending_quotients.size() == 0);
  endtask

  // Corner operands, zero divisors, exact range limits and clipping.
  task automatic test_directed();
    in_item_t reqs[$];
    reqs.push_back(make_req(0, 0, 0, 0, 1'b0));
    reqs.push_back(make_req(32767, -32768, 0, 0, 1'b1));
    reqs.push_back(make_req(-32768, -32768, 0, 0, 1'b0));
    reqs.push_back(make_req(256, 0, 256, 0, 1'b0));
    reqs.push_back(make_req(0, 256, 0, 256, 1'b1));
    reqs.push_back(make_req(256, 256, 256, -256, 1'b0));
    reqs.push_back(make_req(-32768, 0, 256, 0, 1'b0));
    reqs.push_back(make_req(32767, 0, 256, 0, 1'b0));
    reqs.push_back(make_req(-32768, 0, -256, 0, 1'b0));
    reqs.push_back(make_req(0, -32768, 0, -256, 1'b0));
    reqs.push_back(make_req(32767, 32767, 1, 0, 1'b0));
    reqs.push_back(make_req(-32768, -32768, 0, 1, 1'b0));
    reqs.push_back(make_req(32767, 0, 1, 1, 1'b1));
    reqs.push_back(make_req(-32768, -32768, -32768, -32768, 1'b0));
    reqs.push_back(make_req(32767, 32767, 32767, 32767, 1'b0));
    reqs.push_back(make_req(32767, -32768, -32768, 32767, 1'b0));
    reqs.push_back(make_req(0, 0, -32768, -32768, 1'b0));
    reqs.push_back(make_req(1, 1, -32768, -32768, 1'b0));
    reqs.push_back(make_req(-1, -1, -1, -1, 1'b0));
    reqs.push_back(make_req(-1, 0, 32767, 0, 1'b0));
    reqs.push_back(make_req(300, 0, 1, 0, 1'b0));
    reqs.push_back(make_req(127, 0, 1, 0, 1'b0));
    reqs.push_back(make_req(-128, 0, 1, 0, 1'b1));
    foreach (reqs[i]) begin
      send_req(reqs[i]);
    end
    wait_idle();
  endtask

  // The receiver holds off for a long stretch while requests keep coming.
  task automatic test_backpressure();
    gaps_on  = 1'b0;
    hold_req = 1'b1;
    repeat (80) begin
      send_req(random_req());
    end
    wait_idle();
  endtask

  task automatic test_random_gaps(int count);
    gaps_on = 1'b1;
    repeat (count) begin
      send_req(random_req());
    end
    wait_idle();
  endtask

  // Back-to-back streaming with no idling on either side.
  task automatic test_streaming(int count);
    gaps_on = 1'b0;
    repeat (count) begin
      send_req(random_req());
    end
    wait_idle();
  endtask

  // Main sequence.
  initial begin
    gaps_on  = 1'b0;
    hold_req = 1'b0;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.dividend_re <= '0;
    in_ch.dividend_im <= '0;
    in_ch.divisor_re  <= '0;
    in_ch.divisor_im  <= '0;
    in_ch.last_in     <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_gaps(700);
    test_backpressure();
    test_random_gaps(650);
    test_streaming(250);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("PASS complex_divide_stream_unit");
    end else begin
      $display("FAIL complex_divide_stream_unit");
    end
    $finish;
  end

  // Receiver: random stall bursts, plus a long hold when one is requested.
  initial begin
    hold_left  = 0;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 9) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Every accepted input request leaves its expected quotient in the queue.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      pending_quotients.push_back(divide_complex(make_req(in_ch.dividend_re,
        in_ch.dividend_im, in_ch.divisor_re, in_ch.divisor_im, in_ch.last_in)));
    end
  end

  // Each accepted result request is compared with the oldest expectation.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.quotient_re  = out_ch.quotient_re;
      got.quotient_im  = out_ch.quotient_im;
      got.zero_divisor = out_ch.zero_divisor;
      got.saturated    = out_ch.saturated;
      got.last_out     = out_ch.last_out;
      if (pending_quotients.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS) begin
          $display("Unexpected result at cycle %0d: re=%0d im=%0d zero=%0b sat=%0b last=%0b",
                   cycle_cnt, got.quotient_re, got.quotient_im, got.zero_divisor,
                   got.saturated, got.last_out);
        end
      end else begin
        want = pending_quotients.pop_front();
        if (got.quotient_re !== want.quotient_re || got.quotient_im !== want.quotient_im ||
            got.zero_divisor !== want.zero_divisor || got.saturated !== want.saturated ||
            got.last_out !== want.last_out) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS) begin
            $display("Mismatch at cycle %0d: expected re=%0d im=%0d zero=%0b sat=%0b last=%0b",
                     cycle_cnt, want.quotient_re, want.quotient_im, want.zero_divisor,
                     want.saturated, want.last_out);
            $display("  got re=%0d im=%0d zero=%0b sat=%0b last=%0b",
                     got.quotient_re, got.quotient_im, got.zero_divisor,
                     got.saturated, got.last_out);
          end
        end
      end
    end
  end

  // Watchdog on the length of the run.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout with %0d results outstanding", pending_quotients.size());
      $display("FAIL complex_divide_stream_unit");
      $finish;
    end
  end

endmodule
